// File: rtl/bpft_pkg.sv
// Package for the beep pattern and fault tone controller.
// Holds the operation and state types, fixed constants and the
// command and status structs shared by the controller and datapath.
package bpft_pkg;

  localparam int TICK_W = 27;
  localparam int QUOT_W = 26;
  localparam int PERIOD_W = 16;
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [PERIOD_W-1:0] ALARM_PERIOD = 16'd488;
  localparam logic [QUOT_W-1:0] MS_SCALE = 26'd1000;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BEEP  = 2'd1,
    OP_RAISE = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_ON,
    ST_DIV_ON,
    ST_LOAD_OFF,
    ST_DIV_OFF,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_load;
    logic div_load_off;
    logic div_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic beep_start;
  } status_t;

endpackage

// File: rtl/beep_pattern_and_fault_tone_controller_unit.sv
// Beep pattern and fault tone controller, top level; uses bpft_ctrl, bpft_dp, bpft_pkg.
// Tick, raise and clear transactions go from capture to the finish state, which
// commits the result once the output slot is free. An accepted beep request runs
// two 26-step serial divisions through one shared divider. A refused one keeps the
// sequencer and fault state. The result register frees the input. Synchronous
// active-high reset clears FSM, sequencer and fault state and sets tone reload to 488.
module beep_pattern_and_fault_tone_controller_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [15:0] on_ms,
  input  logic [15:0] off_ms,
  input  logic [7:0]  beep_count,
  input  logic [1:0]  fault_id,
  input  logic        bot_enabled,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        tone_on,
  output logic [15:0] tone_period,
  output logic [14:0] tone_compare,
  output logic        ticking,
  output logic        fault_active,
  output logic        accepted
);

  bpft_pkg::cmd_t    cmd;
  bpft_pkg::status_t status;

  bpft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bpft_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .operation      (operation),
    .on_ms          (on_ms),
    .off_ms         (off_ms),
    .beep_count     (beep_count),
    .fault_id       (fault_id),
    .bot_enabled    (bot_enabled),
    .tone_on        (tone_on),
    .tone_period    (tone_period),
    .tone_compare   (tone_compare),
    .ticking        (ticking),
    .fault_active   (fault_active),
    .accepted       (accepted)
  );

endmodule

// File: rtl/bpft_ctrl.sv
// Controller state machine for the beep pattern and fault tone controller.
// Sequences capture, the two serial divisions and the commit of each transaction.
// Depends on bpft_pkg.
module bpft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bpft_pkg::status_t status,
  output bpft_pkg::cmd_t    cmd
);

  bpft_pkg::state_t state;
  bpft_pkg::state_t state_next;
  logic [bpft_pkg::STEP_W-1:0] step_cnt;
  logic last_step;
  logic slot_free;

  assign last_step = (step_cnt == bpft_pkg::STEP_W'(bpft_pkg::DIV_STEPS - 1));
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      bpft_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.beep_start ? bpft_pkg::ST_LOAD_ON : bpft_pkg::ST_FINISH;
        end
      end
      bpft_pkg::ST_LOAD_ON: begin
        state_next = bpft_pkg::ST_DIV_ON;
      end
      bpft_pkg::ST_DIV_ON: begin
        if (last_step) state_next = bpft_pkg::ST_LOAD_OFF;
      end
      bpft_pkg::ST_LOAD_OFF: begin
        state_next = bpft_pkg::ST_DIV_OFF;
      end
      bpft_pkg::ST_DIV_OFF: begin
        if (last_step) state_next = bpft_pkg::ST_FINISH;
      end
      bpft_pkg::ST_FINISH: begin
        if (slot_free) state_next = bpft_pkg::ST_IDLE;
      end
      default: begin
        state_next = bpft_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready         = 1'b0;
    cmd              = '0;
    unique case (state)
      bpft_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      bpft_pkg::ST_LOAD_ON: begin
        cmd.div_load = 1'b1;
      end
      bpft_pkg::ST_DIV_ON: begin
        cmd.div_step = 1'b1;
      end
      bpft_pkg::ST_LOAD_OFF: begin
        cmd.div_load     = 1'b1;
        cmd.div_load_off = 1'b1;
      end
      bpft_pkg::ST_DIV_OFF: begin
        cmd.div_step = 1'b1;
      end
      bpft_pkg::ST_FINISH: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpft_pkg::ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_load) begin
        step_cnt <= '0;
      end else if (cmd.div_step) begin
        step_cnt <= step_cnt + 1'b1;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/bpft_dp.sv
// Datapath for the beep pattern and fault tone controller.
// Holds the tone reload register, sequencer and fault state, a restoring divider
// and the result register. Depends on bpft_pkg.
module bpft_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bpft_pkg::cmd_t                  cmd,
  output bpft_pkg::status_t               status,
  input  logic                            cfg_write_en,
  input  logic [bpft_pkg::PERIOD_W-1:0]   cfg_write_data,
  input  logic [1:0]                      operation,
  input  logic [15:0]                     on_ms,
  input  logic [15:0]                     off_ms,
  input  logic [7:0]                      beep_count,
  input  logic [1:0]                      fault_id,
  input  logic                            bot_enabled,
  output logic                            tone_on,
  output logic [bpft_pkg::PERIOD_W-1:0]   tone_period,
  output logic [14:0]                     tone_compare,
  output logic                            ticking,
  output logic                            fault_active,
  output logic                            accepted
);

  logic [bpft_pkg::PERIOD_W-1:0] tone_reload;

  logic [1:0]  op_r;
  logic [15:0] on_ms_r;
  logic [15:0] off_ms_r;
  logic [7:0]  count_r;
  logic [1:0]  fid_r;
  logic        bot_r;

  logic [2:0]                  fault_flags;
  logic                        alarm_latched;
  logic [bpft_pkg::TICK_W-1:0] on_ticks;
  logic [bpft_pkg::TICK_W-1:0] period_ticks;
  logic [7:0]                  wanted_beeps;
  logic [7:0]                  done_beeps;
  logic [bpft_pkg::TICK_W-1:0] tick_count;
  logic                        tone_running;
  logic                        sequencer_running;
  logic                        alarm_period_select;

  logic [2:0]                  fault_flags_next;
  logic                        alarm_latched_next;
  logic [bpft_pkg::TICK_W-1:0] on_ticks_next;
  logic [bpft_pkg::TICK_W-1:0] period_ticks_next;
  logic [7:0]                  wanted_beeps_next;
  logic [7:0]                  done_beeps_next;
  logic [bpft_pkg::TICK_W-1:0] tick_count_next;
  logic                        tone_running_next;
  logic                        sequencer_running_next;
  logic                        alarm_period_select_next;
  logic                        accepted_next;
  logic [bpft_pkg::PERIOD_W-1:0] period_next;

  logic [bpft_pkg::QUOT_W-1:0] quot;
  logic [bpft_pkg::QUOT_W-1:0] on_quot;
  logic [15:0]                 rem;
  logic [bpft_pkg::QUOT_W-1:0] dividend;
  logic [16:0]                 rem_shift;
  logic [15:0]                 rem_sub;
  logic                        quot_bit;

  logic [2:0]                  fault_bit;
  logic [2:0]                  raised_flags;
  logic [2:0]                  cleared_flags;
  logic [bpft_pkg::TICK_W-1:0] tick_base;
  logic [7:0]                  done_inc;

  assign status.beep_start = (bpft_pkg::op_t'(operation) == bpft_pkg::OP_BEEP) && !alarm_latched;

  // The multiplier output feeds the divider register directly.
  assign dividend = (cmd.div_load_off ? bpft_pkg::QUOT_W'(off_ms_r) : bpft_pkg::QUOT_W'(on_ms_r))
                    * bpft_pkg::MS_SCALE;

  // With a zero reload every quotient bit comes out set, which gives the
  // saturated tick count.
  assign rem_shift = {rem, quot[bpft_pkg::QUOT_W-1]};
  assign rem_sub   = rem_shift[15:0] - tone_reload;
  assign quot_bit  = (rem_shift >= {1'b0, tone_reload});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quot <= dividend;
      rem  <= '0;
      if (cmd.div_load_off) on_quot <= quot;
    end else if (cmd.div_step) begin
      quot <= {quot[bpft_pkg::QUOT_W-2:0], quot_bit};
      rem  <= quot_bit ? rem_sub : rem_shift[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= operation;
      on_ms_r  <= on_ms;
      off_ms_r <= off_ms;
      count_r  <= beep_count;
      fid_r    <= fault_id;
      bot_r    <= bot_enabled;
    end
  end

  always_comb begin
    fault_bit     = (fid_r == 2'd3) ? 3'b000 : (3'b001 << fid_r);
    raised_flags  = fault_flags | fault_bit;
    cleared_flags = fault_flags & ~fault_bit;
    done_inc      = done_beeps + 8'd1;

    fault_flags_next         = fault_flags;
    alarm_latched_next       = alarm_latched;
    on_ticks_next            = on_ticks;
    period_ticks_next        = period_ticks;
    wanted_beeps_next        = wanted_beeps;
    done_beeps_next          = done_beeps;
    tick_count_next          = tick_count;
    tone_running_next        = tone_running;
    sequencer_running_next   = sequencer_running;
    alarm_period_select_next = alarm_period_select;
    accepted_next            = 1'b0;
    tick_base                = tick_count;

    unique case (bpft_pkg::op_t'(op_r))
      bpft_pkg::OP_TICK: begin
        if (sequencer_running) begin
          if (done_beeps < wanted_beeps) begin
            if (tick_count == on_ticks) begin
              tone_running_next = 1'b0;
            end else if (tick_count >= period_ticks) begin
              done_beeps_next = done_inc;
              tick_base       = '0;
              if (done_inc < wanted_beeps) tone_running_next = 1'b1;
            end
            tick_count_next = tick_base + 1'b1;
          end else begin
            tone_running_next      = 1'b0;
            sequencer_running_next = 1'b0;
          end
        end
      end
      bpft_pkg::OP_BEEP: begin
        if (!alarm_latched) begin
          tick_count_next        = '0;
          done_beeps_next        = '0;
          on_ticks_next          = {1'b0, on_quot};
          period_ticks_next      = {1'b0, on_quot} + {1'b0, quot};
          wanted_beeps_next      = count_r;
          sequencer_running_next = 1'b1;
          tone_running_next      = 1'b1;
          accepted_next          = 1'b1;
        end
      end
      bpft_pkg::OP_RAISE: begin
        fault_flags_next = raised_flags;
        if ((raised_flags != 3'b000) && bot_r) begin
          alarm_latched_next       = 1'b1;
          alarm_period_select_next = 1'b1;
          tone_running_next        = 1'b1;
        end
      end
      bpft_pkg::OP_CLEAR: begin
        fault_flags_next = cleared_flags;
        if (cleared_flags == 3'b000) begin
          alarm_latched_next       = 1'b0;
          alarm_period_select_next = 1'b0;
          tone_running_next        = 1'b0;
        end
      end
      default: begin
        accepted_next = 1'b0;
      end
    endcase

    period_next = alarm_period_select_next ? bpft_pkg::ALARM_PERIOD : tone_reload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_reload         <= bpft_pkg::ALARM_PERIOD;
      fault_flags         <= '0;
      alarm_latched       <= 1'b0;
      on_ticks            <= '0;
      period_ticks        <= '0;
      wanted_beeps        <= '0;
      done_beeps          <= '0;
      tick_count          <= '0;
      tone_running        <= 1'b0;
      sequencer_running   <= 1'b0;
      alarm_period_select <= 1'b0;
    end else begin
      if (cfg_write_en) tone_reload <= cfg_write_data;
      if (cmd.commit) begin
        fault_flags         <= fault_flags_next;
        alarm_latched       <= alarm_latched_next;
        on_ticks            <= on_ticks_next;
        period_ticks        <= period_ticks_next;
        wanted_beeps        <= wanted_beeps_next;
        done_beeps          <= done_beeps_next;
        tick_count          <= tick_count_next;
        tone_running        <= tone_running_next;
        sequencer_running   <= sequencer_running_next;
        alarm_period_select <= alarm_period_select_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tone_on      <= tone_running_next;
      tone_period  <= period_next;
      tone_compare <= period_next[bpft_pkg::PERIOD_W-1:1];
      ticking      <= sequencer_running_next;
      fault_active <= alarm_latched_next;
      accepted     <= accepted_next;
    end
  end

endmodule

// File: rtl/bpft_checker.sv
// Port-level checker for the beep pattern and fault tone controller.
// Bound to beep_pattern_and_fault_tone_controller_unit; depends on bpft_pkg.
module bpft_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        tone_on,
  input logic [15:0] tone_period,
  input logic [14:0] tone_compare,
  input logic        ticking,
  input logic        fault_active,
  input logic        accepted
);

  // The alarm always plays the fixed alarm period.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && fault_active |-> tone_period == bpft_pkg::ALARM_PERIOD)
    else $error("alarm result without the alarm period");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> tone_compare == tone_period[15:1])
    else $error("compare value is not half the period");

  // A started beep leaves the tone and the sequencer running with no alarm.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> tone_on && ticking && !fault_active)
    else $error("accepted beep request with inconsistent status");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tone_period) && $stable(tone_on)
      && $stable(accepted))
    else $error("stalled result changed");

endmodule

bind beep_pattern_and_fault_tone_controller_unit bpft_checker u_bpft_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .tone_on      (tone_on),
  .tone_period  (tone_period),
  .tone_compare (tone_compare),
  .ticking      (ticking),
  .fault_active (fault_active),
  .accepted     (accepted)
);
